[rtl/cts_pkg.sv]
package cts_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_SHIFT    = 61 - COORD_WIDTH;
    localparam int CORDIC_STAGES = 30;
    localparam int ATAN_ENTRIES  = 40;

    // root cell datapath
    localparam int SQ_ROOT_W = 64;
    localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;
    localparam int SQ_REM_W  = SQ_ROOT_W + 4;

    // cordic cell datapath
    localparam int CD_W  = 64;
    localparam int ACC_W = 34;

    // cell counts
    localparam int H_STEPS   = 64;
    localparam int MAG_STEPS = 33;

    // pipeline stage numbers
    localparam int ST_SQ   = 3;
    localparam int ST_MAG  = ST_SQ + MAG_STEPS;
    localparam int ST_ELV  = ST_SQ + H_STEPS;
    localparam int ST_ANG  = ST_ELV + CORDIC_STAGES;
    localparam int ST_PROD = ST_ANG + 2;
    localparam int ST_OUT  = ST_PROD + 1;

    localparam logic [30:0] RAD_PER_TURN = 31'd1686629713;
    localparam logic [30:0] DEG_PER_TURN = 31'd1509949440;
    localparam logic [30:0] QUARTER_BA   = 31'd1073741824;

    localparam logic [0:0] REG_ANGLE_UNIT = 1'b0;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] az;
        logic                   nx;
        logic                   ny;
        logic                   nz;
        logic                   zero;
        logic                   hzero;
    } cts_side_t;

    localparam logic [29:0] ATAN_BA [ATAN_ENTRIES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1,
        30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0, 30'd0
    };

    // arctangent of 2^-i in binary angle units, zero past the table
    function automatic logic [ACC_W-1:0] cts_atan(input logic [5:0] i);
        logic [ACC_W-1:0] r;
        r = '0;
        if (int'(i) < ATAN_ENTRIES)
        begin
            r = ACC_W'(ATAN_BA[i]);
        end
        return r;
    endfunction

endpackage

[rtl/cartesian_to_spherical_top.sv]
// Cartesian to spherical converter: one signed 32-bit x, y, z item in, one item out with
// azimuth (0 up to one turn), elevation (within a quarter turn), rounded length and a
// zero-vector flag. A new item is taken every cycle while the output is not stalled; each
// result passes through the chain of 64 square-root cells that forms the
// horizontal length, followed by the 30 CORDIC cells of the elevation, plus input, squaring
// and unit-conversion stages. The whole pipeline advances together and holds while the
// output item is not taken. Register 0 bit 0 picks the angle unit: 0 radians * 2^28,
// 1 degrees * 2^22; write it only while no item is in flight.
module cartesian_to_spherical_top (
    input  logic         clk,
    input  logic         rst_n,
    // x [31:0], y [63:32], z [95:64]
    input  logic [95:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // azimuth [30:0], elevation [60:31], magnitude [92:61], zero pad [95:93]
    output logic [95:0]  m_tdata,
    // zero_vector [0]
    output logic [0:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cts_pkg::*;

    logic                   deg_reg;
    logic                   en;
    logic [ST_OUT:0]        vld_reg;
    cts_side_t              sb_reg [ST_ANG+1];
    cts_side_t              side_in;
    logic signed [COORD_WIDTH-1:0] ix;
    logic signed [COORD_WIDTH-1:0] iy;
    logic signed [COORD_WIDTH-1:0] iz;
    logic [COORD_WIDTH-1:0] ax_reg;
    logic [COORD_WIDTH-1:0] ay_reg;
    logic [63:0]            px_reg;
    logic [63:0]            py_reg;
    logic [63:0]            pz_reg;
    logic [63:0]            pz2_reg;
    logic [64:0]            s2_reg;
    logic [64:0]            s2b_reg;
    logic [65:0]            s3_reg;

    logic [SQ_RAD_W-1:0]    hrad  [H_STEPS+1];
    logic [SQ_ROOT_W-1:0]   hroot [H_STEPS+1];
    logic [SQ_REM_W-1:0]    hrem  [H_STEPS+1];
    logic [SQ_RAD_W-1:0]    mrad  [MAG_STEPS+1];
    logic [SQ_ROOT_W-1:0]   mroot [MAG_STEPS+1];
    logic [SQ_REM_W-1:0]    mrem  [MAG_STEPS+1];

    logic signed [CD_W-1:0]  axc  [CORDIC_STAGES+1];
    logic signed [CD_W-1:0]  ayc  [CORDIC_STAGES+1];
    logic signed [ACC_W-1:0] aacc [CORDIC_STAGES+1];
    logic signed [CD_W-1:0]  exc  [CORDIC_STAGES+1];
    logic signed [CD_W-1:0]  eyc  [CORDIC_STAGES+1];
    logic signed [ACC_W-1:0] eacc [CORDIC_STAGES+1];

    logic signed [ACC_W-1:0] azd_reg  [ST_ANG-CORDIC_STAGES];
    logic [COORD_WIDTH-1:0]  magd_reg [ST_ANG-ST_MAG];
    logic                    mag_up;
    logic [COORD_WIDTH-1:0]  mag_rnd;

    logic [30:0]            azimuth;
    logic [29:0]            elevation;
    logic [COORD_WIDTH-1:0] magnitude;
    logic                   zero_vector;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ANGLE_UNIT) ? {31'd0, deg_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_ANGLE_UNIT)
        begin
            deg_reg <= pwdata[0];
        end
    end

    // whole pipeline moves when the output slot frees
    assign en       = !vld_reg[ST_OUT] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ST_OUT-1:0], s_tvalid};
        end
    end

    // input decode: magnitudes and sign flags
    always_comb
    begin
        ix            = signed'(s_tdata[31:0]);
        iy            = signed'(s_tdata[63:32]);
        iz            = signed'(s_tdata[95:64]);
        side_in.az    = iz[COORD_WIDTH-1] ? COORD_WIDTH'(-iz) : COORD_WIDTH'(iz);
        side_in.nx    = ix[COORD_WIDTH-1];
        side_in.ny    = iy[COORD_WIDTH-1];
        side_in.nz    = iz[COORD_WIDTH-1];
        side_in.hzero = (ix == 0) && (iy == 0);
        side_in.zero  = (ix == 0) && (iy == 0) && (iz == 0);
    end

    // sideband shift line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= side_in;
            for (int k = 1; k <= ST_ANG; k++)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // squares and sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg  <= ix[COORD_WIDTH-1] ? COORD_WIDTH'(-ix) : COORD_WIDTH'(ix);
            ay_reg  <= iy[COORD_WIDTH-1] ? COORD_WIDTH'(-iy) : COORD_WIDTH'(iy);
            px_reg  <= 64'(ax_reg) * 64'(ax_reg);
            py_reg  <= 64'(ay_reg) * 64'(ay_reg);
            pz_reg  <= 64'(sb_reg[0].az) * 64'(sb_reg[0].az);
            s2_reg  <= 65'(px_reg) + 65'(py_reg);
            pz2_reg <= pz_reg;
            s3_reg  <= 66'(s2_reg) + 66'(pz2_reg);
            s2b_reg <= s2_reg;
        end
    end

    // root chains: length and horizontal length
    assign hrad[0]  = SQ_RAD_W'(s2b_reg) << (2 * FRAC_SHIFT);
    assign hroot[0] = '0;
    assign hrem[0]  = '0;
    assign mrad[0]  = {s3_reg, (SQ_RAD_W-66)'(0)};
    assign mroot[0] = '0;
    assign mrem[0]  = '0;

    for (genvar g = 0; g < H_STEPS; g++)
    begin : g_hsq
        cts_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .rad_in   (hrad[g]),
            .root_in  (hroot[g]),
            .rem_in   (hrem[g]),
            .rad_out  (hrad[g+1]),
            .root_out (hroot[g+1]),
            .rem_out  (hrem[g+1])
        );
    end

    for (genvar g = 0; g < MAG_STEPS; g++)
    begin : g_msq
        cts_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .rad_in   (mrad[g]),
            .root_in  (mroot[g]),
            .rem_in   (mrem[g]),
            .rad_out  (mrad[g+1]),
            .root_out (mroot[g+1]),
            .rem_out  (mrem[g+1])
        );
    end

    // round the length half up: remainder above root
    always_comb
    begin
        mag_up  = mrem[MAG_STEPS] > SQ_REM_W'(mroot[MAG_STEPS]);
        mag_rnd = COORD_WIDTH'(mroot[MAG_STEPS] + SQ_ROOT_W'(mag_up));
    end

    // azimuth cordic cells on the folded x, y
    assign axc[0]  = CD_W'(ax_reg) << FRAC_SHIFT;
    assign ayc[0]  = CD_W'(ay_reg) << FRAC_SHIFT;
    assign aacc[0] = '0;

    // elevation cordic cells on horizontal length and |z|
    assign exc[0]  = signed'(hroot[H_STEPS]);
    assign eyc[0]  = CD_W'(sb_reg[ST_ELV].az) << FRAC_SHIFT;
    assign eacc[0] = '0;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        cts_cordic_cell u_az (
            .clk     (clk),
            .en      (en),
            .stage   (6'(g)),
            .x_in    (axc[g]),
            .y_in    (ayc[g]),
            .acc_in  (aacc[g]),
            .x_out   (axc[g+1]),
            .y_out   (ayc[g+1]),
            .acc_out (aacc[g+1])
        );
        cts_cordic_cell u_el (
            .clk     (clk),
            .en      (en),
            .stage   (6'(g)),
            .x_in    (exc[g]),
            .y_in    (eyc[g]),
            .acc_in  (eacc[g]),
            .x_out   (exc[g+1]),
            .y_out   (eyc[g+1]),
            .acc_out (eacc[g+1])
        );
    end

    // align azimuth angle and length with the elevation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            azd_reg[0] <= aacc[CORDIC_STAGES];
            for (int k = 1; k < ST_ANG - CORDIC_STAGES; k++)
            begin
                azd_reg[k] <= azd_reg[k-1];
            end
            magd_reg[0] <= mag_rnd;
            for (int k = 1; k < ST_ANG - ST_MAG; k++)
            begin
                magd_reg[k] <= magd_reg[k-1];
            end
        end
    end

    cts_convert u_convert (
        .clk         (clk),
        .en          (en),
        .deg         (deg_reg),
        .az_acc      (azd_reg[ST_ANG-CORDIC_STAGES-1]),
        .el_acc      (eacc[CORDIC_STAGES]),
        .side_in     (sb_reg[ST_ANG]),
        .mag_in      (magd_reg[ST_ANG-ST_MAG-1]),
        .azimuth     (azimuth),
        .elevation   (elevation),
        .magnitude   (magnitude),
        .zero_vector (zero_vector)
    );

    assign m_tdata = {3'b000, magnitude, elevation, azimuth};
    assign m_tuser = zero_vector;

endmodule

[rtl/cts_sqrt_cell.sv]
module cts_sqrt_cell (
    input  logic                            clk,
    input  logic                            en,
    input  logic [cts_pkg::SQ_RAD_W-1:0]    rad_in,
    input  logic [cts_pkg::SQ_ROOT_W-1:0]   root_in,
    input  logic [cts_pkg::SQ_REM_W-1:0]    rem_in,
    output logic [cts_pkg::SQ_RAD_W-1:0]    rad_out,
    output logic [cts_pkg::SQ_ROOT_W-1:0]   root_out,
    output logic [cts_pkg::SQ_REM_W-1:0]    rem_out
);
    import cts_pkg::*;

    logic [SQ_REM_W-1:0] rem2;
    logic [SQ_REM_W-1:0] trial;
    logic                fits;

    // bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem2  = {rem_in[SQ_REM_W-3:0], rad_in[SQ_RAD_W-1 -: 2]};
        trial = SQ_REM_W'({root_in, 2'b01});
        fits  = (rem2 >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out <= {rad_in[SQ_RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_out  <= rem2 - trial;
                root_out <= {root_in[SQ_ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_out  <= rem2;
                root_out <= {root_in[SQ_ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

[rtl/cts_cordic_cell.sv]
module cts_cordic_cell (
    input  logic                                clk,
    input  logic                                en,
    input  logic [5:0]                          stage,
    input  logic signed [cts_pkg::CD_W-1:0]     x_in,
    input  logic signed [cts_pkg::CD_W-1:0]     y_in,
    input  logic signed [cts_pkg::ACC_W-1:0]    acc_in,
    output logic signed [cts_pkg::CD_W-1:0]     x_out,
    output logic signed [cts_pkg::CD_W-1:0]     y_out,
    output logic signed [cts_pkg::ACC_W-1:0]    acc_out
);
    import cts_pkg::*;

    logic signed [CD_W-1:0]  dx;
    logic signed [CD_W-1:0]  dy;
    logic signed [ACC_W-1:0] t;

    // shifted operands and the angle of this rotation
    always_comb
    begin
        dx = y_in >>> stage;
        dy = x_in >>> stage;
        t  = signed'(cts_atan(stage));
    end

    // rotate toward the x axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[CD_W-1])
            begin
                x_out   <= x_in + dx;
                y_out   <= y_in - dy;
                acc_out <= acc_in + t;
            end
            else
            begin
                x_out   <= x_in - dx;
                y_out   <= y_in + dy;
                acc_out <= acc_in - t;
            end
        end
    end

endmodule

[rtl/cts_convert.sv]
module cts_convert (
    input  logic                                clk,
    input  logic                                en,
    input  logic                                deg,
    input  logic signed [cts_pkg::ACC_W-1:0]    az_acc,
    input  logic signed [cts_pkg::ACC_W-1:0]    el_acc,
    input  cts_pkg::cts_side_t                  side_in,
    input  logic [cts_pkg::COORD_WIDTH-1:0]     mag_in,
    output logic [30:0]                         azimuth,
    output logic [29:0]                         elevation,
    output logic [cts_pkg::COORD_WIDTH-1:0]     magnitude,
    output logic                                zero_vector
);
    import cts_pkg::*;

    logic [30:0]            a_az;
    logic [30:0]            a_el;
    logic [32:0]            fold;
    logic [31:0]            az_ba_reg;
    logic [30:0]            el_ba_reg;
    cts_side_t              s1_reg;
    cts_side_t              s2_reg;
    logic [COORD_WIDTH-1:0] m1_reg;
    logic [COORD_WIDTH-1:0] m2_reg;
    logic [62:0]            az_rad_reg;
    logic [62:0]            el_rad_reg;
    logic [37:0]            az_deg_reg;
    logic [37:0]            el_deg_reg;
    logic [63:0]            az_rad_r;
    logic [63:0]            el_rad_r;
    logic [38:0]            az_deg_r;
    logic [38:0]            el_deg_r;
    logic [31:0]            az_u;
    logic [31:0]            el_u;
    logic [31:0]            lim;

    // clamp a cordic angle into one quarter turn
    function automatic logic [30:0] clamp_q(input logic signed [ACC_W-1:0] v);
        logic [30:0] r;
        r = v[30:0];
        if (v[ACC_W-1])
        begin
            r = '0;
        end
        else if (v > signed'(ACC_W'(QUARTER_BA)))
        begin
            r = QUARTER_BA;
        end
        return r;
    endfunction

    // quadrant fold of the first-quadrant azimuth
    always_comb
    begin
        a_az = clamp_q(az_acc);
        a_el = clamp_q(el_acc);
        if (!side_in.nx && !side_in.ny)
        begin
            fold = 33'(a_az);
        end
        else if (side_in.nx && !side_in.ny)
        begin
            fold = 33'h0_8000_0000 - 33'(a_az);
        end
        else if (side_in.nx)
        begin
            fold = 33'h0_8000_0000 + 33'(a_az);
        end
        else
        begin
            fold = 33'h1_0000_0000 - 33'(a_az);
        end
    end

    // binary angles and unit products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_ba_reg <= side_in.hzero ? 32'd0 : fold[31:0];
            el_ba_reg <= side_in.hzero ? QUARTER_BA : a_el;
            s1_reg    <= side_in;
            m1_reg    <= mag_in;

            az_rad_reg <= 63'(az_ba_reg) * 63'(RAD_PER_TURN);
            el_rad_reg <= 63'(el_ba_reg) * 63'(RAD_PER_TURN);
            az_deg_reg <= 38'(az_ba_reg) * 38'd45;
            el_deg_reg <= 38'(el_ba_reg) * 38'd45;
            s2_reg     <= s1_reg;
            m2_reg     <= m1_reg;
        end
    end

    // rounding, wrap at full turn and sign
    always_comb
    begin
        az_rad_r = 64'(az_rad_reg) + 64'h8000_0000;
        el_rad_r = 64'(el_rad_reg) + 64'h8000_0000;
        az_deg_r = 39'(az_deg_reg) + 39'd64;
        el_deg_r = 39'(el_deg_reg) + 39'd64;
        az_u     = deg ? az_deg_r[38:7] : az_rad_r[63:32];
        el_u     = deg ? el_deg_r[38:7] : el_rad_r[63:32];
        lim      = deg ? 32'(DEG_PER_TURN) : 32'(RAD_PER_TURN);
        if (az_u >= lim)
        begin
            az_u = '0;
        end
        if (s2_reg.nz)
        begin
            el_u = 32'd0 - el_u;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_vector <= s2_reg.zero;
            azimuth     <= s2_reg.zero ? 31'd0 : az_u[30:0];
            elevation   <= s2_reg.zero ? 30'd0 : el_u[29:0];
            magnitude   <= s2_reg.zero ? '0 : m2_reg;
        end
    end

endmodule

[rtl/cts_checker.sv]
module cts_props (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tready,
    input  logic [95:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready
);

    // a stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // zero vector gives all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[92:0] == 93'd0)
        else $error("zero vector with nonzero fields");

    // azimuth always below one turn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[30:0] < 31'd1686629713)
        else $error("azimuth reached one turn");

    // input side open whenever the output slot is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

endmodule

bind cartesian_to_spherical_top cts_props u_cts_props (.*);

[bench/cts_checker.sv]
module cts_checker
    import cts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // x [31:0], y [63:32], z [95:64]
    input  logic [95:0]  s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // azimuth [30:0], elevation [60:31], magnitude [92:61], zero pad [95:93]
    input  logic [95:0]  m_tdata,
    // zero_vector [0]
    input  logic [0:0]   m_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [30:0] azimuth;
        logic [29:0] elevation;
        logic [31:0] magnitude;
        logic        zero_vector;
    } sph_t;

    localparam logic [2:0] ADDR_ANGLE_UNIT = 3'(4 * REG_ANGLE_UNIT);

    sph_t sph_q[$];
    logic unit_deg;

    // floor square root of a wide radicand
    function automatic logic [63:0] root_floor(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 62; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s)
                r = c;
        end
        return r;
    endfunction

    // first-quadrant vectoring, binary angle clamped to a quarter turn
    function automatic logic [63:0] vector_angle(input logic signed [63:0] x0,
                                                 input logic signed [63:0] y0);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] acc;
        logic signed [63:0] t;
        x = x0;
        y = y0;
        acc = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            t = (i < ATAN_ENTRIES) ? 64'(ATAN_BA[i]) : 64'sd0;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                acc = acc + t;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                acc = acc - t;
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > 64'(QUARTER_BA))
            acc = 64'(QUARTER_BA);
        return acc;
    endfunction

    function automatic logic [63:0] angle_to_unit(input logic [63:0] a, input logic deg);
        if (deg)
            return (a * 64'd45 + 64'd64) >> 7;
        return (a * 64'(RAD_PER_TURN) + 64'd2147483648) >> 32;
    endfunction

    function automatic sph_t convert(input logic [95:0] d, input logic deg);
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic [63:0]  ax;
        logic [63:0]  ay;
        logic [63:0]  az;
        logic [127:0] s2;
        logic [127:0] s3;
        logic [63:0]  mag;
        logic [63:0]  a;
        logic [63:0]  az_ba;
        logic [63:0]  el_ba;
        logic [63:0]  h;
        logic [63:0]  azim;
        logic [63:0]  elev;
        sph_t r;
        sx = d[31:0];
        sy = d[63:32];
        sz = d[95:64];
        ax = (sx < 0) ? -64'(sx) : 64'(sx);
        ay = (sy < 0) ? -64'(sy) : 64'(sy);
        az = (sz < 0) ? -64'(sz) : 64'(sz);
        r = '0;
        if (ax == 0 && ay == 0 && az == 0)
        begin
            r.zero_vector = 1'b1;
            return r;
        end
        s2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
        s3 = s2 + {64'd0, az} * {64'd0, az};
        mag = root_floor(s3);
        // round half up
        if (s3 > {64'd0, mag} * {64'd0, mag} + {64'd0, mag})
            mag = mag + 1;
        if (ax == 0 && ay == 0)
        begin
            az_ba = 0;
            el_ba = 64'(QUARTER_BA);
        end
        else
        begin
            a = vector_angle(ax << FRAC_SHIFT, ay << FRAC_SHIFT);
            // quadrant folding
            if (sx >= 0 && sy >= 0)
                az_ba = a;
            else if (sx < 0 && sy >= 0)
                az_ba = 64'h8000_0000 - a;
            else if (sx < 0)
                az_ba = 64'h8000_0000 + a;
            else
                az_ba = 64'h1_0000_0000 - a;
            az_ba = az_ba & 64'hFFFF_FFFF;
            h = root_floor(s2 << (2 * FRAC_SHIFT));
            el_ba = vector_angle(h, az << FRAC_SHIFT);
        end
        azim = angle_to_unit(az_ba, deg);
        // a full turn wraps to zero
        if (azim >= 64'(deg ? DEG_PER_TURN : RAD_PER_TURN))
            azim = 0;
        elev = angle_to_unit(el_ba, deg);
        if (sz < 0)
            elev = -elev;
        r.azimuth = azim[30:0];
        r.elevation = elev[29:0];
        r.magnitude = mag[31:0];
        return r;
    endfunction

    assign pending = sph_q.size();

    // track the unit register, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        sph_t exp_r;
        sph_t got;
        if (!rst_n)
        begin
            unit_deg <= 1'b0;
            errors <= 0;
            sph_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ANGLE_UNIT)
                unit_deg <= pwdata[0];
            if (s_tvalid && s_tready)
                sph_q.push_back(convert(s_tdata, unit_deg));
            if (m_tvalid && m_tready)
            begin
                got.azimuth = m_tdata[30:0];
                got.elevation = m_tdata[60:31];
                got.magnitude = m_tdata[92:61];
                got.zero_vector = m_tuser[0];
                if (sph_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("checker: unexpected item az=%0d el=%0d mag=%0d zero=%0b",
                                 got.azimuth, got.elevation, got.magnitude,
                                 got.zero_vector);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_r = sph_q.pop_front();
                    if (got !== exp_r || m_tdata[95:93] !== 3'b000)
                    begin
                        if (errors < 10)
                            $display({"checker: mismatch exp az=%0d el=%0d mag=%0d zero=%0b",
                                      " got az=%0d el=%0d mag=%0d zero=%0b pad=%0h"},
                                     exp_r.azimuth, exp_r.elevation, exp_r.magnitude,
                                     exp_r.zero_vector, got.azimuth, got.elevation,
                                     got.magnitude, got.zero_vector, m_tdata[95:93]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

[bench/tb.sv]
module tb;
    import cts_pkg::*;

    localparam int LIMIT = 2000000;
    localparam logic [2:0] ADDR_ANGLE_UNIT = 3'(4 * REG_ANGLE_UNIT);

    logic        clk;
    logic        rst_n;
    logic [95:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          send_idle;
    int          recv_stall;

    cartesian_to_spherical_top dut (.*);

    cts_checker chk (
        .clk(clk), .rst_n(rst_n), .s_tdata(s_tdata), .s_tvalid(s_tvalid),
        .s_tready(s_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .errors(errors),
        .pending(pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall);

    task automatic send_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        bit taken;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < send_idle)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {z, y, x};
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                taken = 1;
            end
        end
    endtask

    task automatic set_unit(input logic deg);
        // drain so the register changes only while idle
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ANGLE_UNIT;
        pwdata <= {31'($urandom_range(0, 32'h7FFF_FFFF)), deg};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'd0;
        if (pick < 4)
            return $urandom;
        // mostly small magnitudes of either sign
        return 32'($signed($urandom) >>> $urandom_range(1, 31));
    endfunction

    task automatic directed();
        send_vec(0, 0, 0);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vec(32'h8000_0000, 0, 0);
        send_vec(32'h7FFF_FFFF, 0, 0);
        send_vec(0, 32'h7FFF_FFFF, 0);
        send_vec(0, 32'h8000_0000, 0);
        // no horizontal part
        send_vec(0, 0, 32'd5);
        send_vec(0, 0, -32'sd5);
        send_vec(0, 0, 32'h8000_0000);
        // each quadrant
        send_vec(32'd3, 32'd4, 32'd12);
        send_vec(-32'sd3, 32'd4, -32'sd12);
        send_vec(-32'sd3, -32'sd4, 32'd1);
        send_vec(32'd3, -32'sd4, -32'sd1);
        // azimuth just under a full turn
        send_vec(32'h7FFF_FFFF, -32'sd1, 0);
        send_vec(32'd1000000, -32'sd1, 32'd7);
        send_vec(-32'sd1, 0, 0);
        send_vec(-32'sd1, -32'sd1, -32'sd1);
        send_vec(32'd1, 32'd1, 32'd1);
        send_vec(32'd1, 32'd2, 32'd2);
        send_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
    endtask

    initial
    begin
        int idle_set[4][2];
        idle_set = '{'{0, 0}, '{62, 0}, '{0, 62}, '{27, 27}};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle = 0;
        recv_stall = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phases alternate the angle unit
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = 0;
            recv_stall = 0;
            set_unit(ph[0]);
            if (ph < 2)
                directed();
            for (int k = 0; k < 260; k++)
            begin
                send_idle = idle_set[k / 65][0];
                recv_stall = idle_set[k / 65][1];
                send_vec(rand_coord(), rand_coord(), rand_coord());
            end
        end

        // drain and settle
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
